[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked on the rising edge
// and disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fbar_pkg.sv]
// ---------------------------------------------------------------------------
// Fence breach alarm reporter package
// Types, register defaults and report code helper shared by the block.
// ---------------------------------------------------------------------------
package fbar_pkg;

  localparam int unsigned TimerW   = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CodeW    = 14;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [IntervalW-1:0] BreachTicksRst   = 16'd2400;
  localparam logic [IntervalW-1:0] AlertIntTicksRst = 16'd2000;
  localparam logic [TimerW-1:0]    HeartbeatTicksRst = 32'd3600000;

  localparam logic [CodeW-1:0] CodeBaseLeft      = 14'd13200;
  localparam logic [CodeW-1:0] CodeBaseRight     = 14'd13300;
  localparam logic [CodeW-1:0] CodeBaseLid       = 14'd13400;
  localparam logic [CodeW-1:0] CodeBaseHeartbeat = 14'd13500;
  localparam logic [CodeW-1:0] CodeMax           = 14'd13508;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BREACH_TICKS    = 2'd0,
    REG_ALERT_INTERVAL  = 2'd1,
    REG_HEARTBEAT_TICKS = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CAUSE_LEFT      = 2'd0,
    CAUSE_RIGHT     = 2'd1,
    CAUSE_LID       = 2'd2,
    CAUSE_HEARTBEAT = 2'd3
  } cause_t;

  typedef struct packed {
    logic right_side_closed;
    logic right_centre_closed;
    logic left_side_closed;
    logic left_centre_closed;
    logic lid_open;
  } sensor_t;

  typedef struct packed {
    logic [IntervalW-1:0] breach_ticks;
    logic [IntervalW-1:0] alert_interval_ticks;
    logic [TimerW-1:0]    heartbeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic             report_valid;
    logic [CodeW-1:0] report_code;
    logic             alert_active;
    logic             left_alarm;
    logic             right_alarm;
  } result_t;

  function automatic logic [CodeW-1:0] make_code(cause_t cause, logic left, logic right,
                                                 logic lid);
    logic [CodeW-1:0] base;
    unique case (cause)
      CAUSE_LEFT:  base = CodeBaseLeft;
      CAUSE_RIGHT: base = CodeBaseRight;
      CAUSE_LID:   base = CodeBaseLid;
      default:     base = CodeBaseHeartbeat;
    endcase
    return base + {13'd0, left} + {12'd0, right, 1'b0} + (lid ? 14'd5 : 14'd0);
  endfunction

endpackage

[hw/rtl/fence_breach_alarm_reporter.sv]
// ---------------------------------------------------------------------------
// Fence breach alarm reporter
// Turns one millisecond tick of fence switch and lid levels into one status
// item with an optional alert or heartbeat report code.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one item per tick with the four switch levels and
//   the lid level, taken when in_valid and in_ready are both high.
//   Output channel out_*: exactly one item per input item, in order, taken
//   when out_valid and out_ready are both high.
//   Configuration port cfg_*: register index 0 breach ticks, 1 alert interval
//   ticks, 2 heartbeat ticks; written when cfg_write_en is high. Write only while
//   the block is idle; the block itself does not enforce this. Other indexes are ignored.
//   Path: an accepted item is held in the input register, then the result
//   register is loaded from the tick logic.
//   Throughput: 1 item per cycle while out_ready does not stall the output; the
//   timer and alert state closes its feedback loop through combinational logic.
//   Reset: timers and alarm history clear, alert off, cause heartbeat,
//   registers return to their defaults; both stages empty.
//   Stall: while out_ready is low the result register holds, the input
//   register takes one more item, then in_ready drops until the result moves.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fence_breach_alarm_reporter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_right_side_closed,
  input  logic                                 in_right_centre_closed,
  input  logic                                 in_left_side_closed,
  input  logic                                 in_left_centre_closed,
  input  logic                                 in_lid_open,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_report_valid,
  output logic [fbar_pkg::CodeW-1:0]           out_report_code,
  output logic                                 out_alert_active,
  output logic                                 out_left_alarm,
  output logic                                 out_right_alarm,
  input  logic                                 cfg_write_en,
  input  logic [fbar_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [fbar_pkg::CfgDataW-1:0]        cfg_data
);

  fbar_pkg::cfg_t    cfg_r;
  logic              stage_valid_r;
  fbar_pkg::sensor_t stage_r;
  logic              out_valid_r;
  fbar_pkg::result_t out_r;
  fbar_pkg::result_t tick_result;
  logic              advance;

  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.breach_ticks         <= fbar_pkg::BreachTicksRst;
      cfg_r.alert_interval_ticks <= fbar_pkg::AlertIntTicksRst;
      cfg_r.heartbeat_ticks      <= fbar_pkg::HeartbeatTicksRst;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        fbar_pkg::REG_BREACH_TICKS:
          cfg_r.breach_ticks <= cfg_data[fbar_pkg::IntervalW-1:0];
        fbar_pkg::REG_ALERT_INTERVAL:
          cfg_r.alert_interval_ticks <= cfg_data[fbar_pkg::IntervalW-1:0];
        fbar_pkg::REG_HEARTBEAT_TICKS:
          cfg_r.heartbeat_ticks <= cfg_data[fbar_pkg::TimerW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r.right_side_closed   <= in_right_side_closed;
      stage_r.right_centre_closed <= in_right_centre_closed;
      stage_r.left_side_closed    <= in_left_side_closed;
      stage_r.left_centre_closed  <= in_left_centre_closed;
      stage_r.lid_open            <= in_lid_open;
    end
  end

  fbar_tick u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .sensor  (stage_r),
    .cfg     (cfg_r),
    .result  (tick_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= tick_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_report_valid = out_r.report_valid;
  assign out_report_code  = out_r.report_code;
  assign out_alert_active = out_r.alert_active;
  assign out_left_alarm   = out_r.left_alarm;
  assign out_right_alarm  = out_r.right_alarm;

  `ASSERT_SAME(a_code_zero_idle, clk, rst_n, out_valid_r && !out_r.report_valid,
               out_r.report_code == '0, "report code set without a report")
  `ASSERT_SAME(a_code_range, clk, rst_n, out_valid_r && out_r.report_valid,
               (out_r.report_code >= fbar_pkg::CodeBaseLeft) &&
               (out_r.report_code <= fbar_pkg::CodeMax), "report code out of range")
  `ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid_r && out_valid_r && !out_ready,
               stage_valid_r && $stable(stage_r), "input register lost an item on stall")
  `ASSERT_SAME(a_ready_only_full, clk, rst_n, !in_ready,
               stage_valid_r && out_valid_r, "input stalled with a free stage")

endmodule

[hw/rtl/fbar_tick.sv]
// ---------------------------------------------------------------------------
// Fence breach tick engine
// Holds the alarm timers and alert state and forms the result of one tick.
// ---------------------------------------------------------------------------
module fbar_tick (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  fbar_pkg::sensor_t sensor,
  input  fbar_pkg::cfg_t    cfg,
  output fbar_pkg::result_t result
);

  localparam logic [fbar_pkg::TimerW-1:0] TimerMax = '1;

  logic                          left_prev_r, left_prev_nxt;
  logic                          right_prev_r, right_prev_nxt;
  logic [fbar_pkg::TimerW-1:0]   left_elapsed_r, left_elapsed_nxt;
  logic [fbar_pkg::TimerW-1:0]   right_elapsed_r, right_elapsed_nxt;
  logic [fbar_pkg::TimerW-1:0]   since_report_r, since_report_nxt;
  logic                          alert_r, alert_nxt;
  fbar_pkg::cause_t              cause_r, cause_nxt;

  logic                          left_alarm, right_alarm;
  logic [fbar_pkg::TimerW-1:0]   since_inc, since_mid;
  logic [fbar_pkg::TimerW-1:0]   breach_ext, interval_ext;
  logic                          alert_raised;
  fbar_pkg::cause_t              cause_mid;
  logic                          alert_report, alert_clear, heartbeat;

  always_comb begin
    left_alarm  = !(sensor.left_side_closed && !sensor.left_centre_closed);
    right_alarm = !(sensor.right_side_closed && !sensor.right_centre_closed);
    breach_ext   = {{(fbar_pkg::TimerW-fbar_pkg::IntervalW){1'b0}}, cfg.breach_ticks};
    interval_ext = {{(fbar_pkg::TimerW-fbar_pkg::IntervalW){1'b0}}, cfg.alert_interval_ticks};

    left_elapsed_nxt  = (left_elapsed_r == TimerMax) ? left_elapsed_r : left_elapsed_r + 1'b1;
    right_elapsed_nxt = (right_elapsed_r == TimerMax) ? right_elapsed_r : right_elapsed_r + 1'b1;
    since_inc         = (since_report_r == TimerMax) ? since_report_r : since_report_r + 1'b1;
    if (left_alarm && !left_prev_r) begin
      left_elapsed_nxt = '0;
    end
    if (right_alarm && !right_prev_r) begin
      right_elapsed_nxt = '0;
    end
    left_prev_nxt  = left_alarm;
    right_prev_nxt = right_alarm;

    alert_raised = 1'b1;
    cause_mid    = cause_r;
    priority if (alert_r) begin
      alert_raised = 1'b0;
    end else if (left_alarm && (left_elapsed_nxt > breach_ext)) begin
      cause_mid = fbar_pkg::CAUSE_LEFT;
    end else if (right_alarm && (right_elapsed_nxt > breach_ext)) begin
      cause_mid = fbar_pkg::CAUSE_RIGHT;
    end else if (sensor.lid_open) begin
      cause_mid = fbar_pkg::CAUSE_LID;
    end else begin
      alert_raised = 1'b0;
    end

    alert_nxt    = alert_r || alert_raised;
    alert_report = alert_nxt && (since_inc > interval_ext);
    alert_clear  = alert_nxt && !sensor.lid_open && !left_alarm && !right_alarm;
    since_mid    = (alert_report || alert_clear) ? '0 : since_inc;
    if (alert_clear) begin
      alert_nxt = 1'b0;
    end

    heartbeat        = since_mid > cfg.heartbeat_ticks;
    since_report_nxt = heartbeat ? '0 : since_mid;
    cause_nxt        = heartbeat ? fbar_pkg::CAUSE_HEARTBEAT : cause_mid;

    result.report_valid = alert_report || heartbeat;
    result.report_code  = (alert_report || heartbeat)
                        ? fbar_pkg::make_code(cause_nxt, left_alarm, right_alarm,
                                              sensor.lid_open)
                        : '0;
    result.alert_active = alert_nxt;
    result.left_alarm   = left_alarm;
    result.right_alarm  = right_alarm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_prev_r     <= 1'b0;
      right_prev_r    <= 1'b0;
      left_elapsed_r  <= '0;
      right_elapsed_r <= '0;
      since_report_r  <= '0;
      alert_r         <= 1'b0;
      cause_r         <= fbar_pkg::CAUSE_HEARTBEAT;
    end else if (step_en) begin
      left_prev_r     <= left_prev_nxt;
      right_prev_r    <= right_prev_nxt;
      left_elapsed_r  <= left_elapsed_nxt;
      right_elapsed_r <= right_elapsed_nxt;
      since_report_r  <= since_report_nxt;
      alert_r         <= alert_nxt;
      cause_r         <= cause_nxt;
    end
  end

endmodule

[dv/tb_fence_breach_alarm_reporter.sv]
// ---------------------------------------------------------------------------
// Fence breach alarm reporter testbench
// Drives switch and lid ticks through the valid/ready input with random gaps
// and receiver stalls. Each tick accepted is run through a tick-accurate
// predictor of the timers, alert state and report codes, and every status
// item that comes out is checked field by field. Registers are rewritten
// between phases while the block is drained: defaults, a directed opening,
// zero, maximum, mixed zero and maximum, and small random settings.
// ---------------------------------------------------------------------------
module tb_fence_breach_alarm_reporter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [fbar_pkg::CfgIdxW-1:0] RegIdxSpare = 2'd3;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned LongHoldCycles = 64;
  localparam int unsigned PhaseTicks = 120;
  localparam int unsigned PhaseCount = 12;

  // {right side, right centre, left side, left centre, lid}
  localparam fbar_pkg::sensor_t SwQuiet       = 5'b10100;
  localparam fbar_pkg::sensor_t SwLeftOpen    = 5'b10000;
  localparam fbar_pkg::sensor_t SwLeftCentre  = 5'b10110;
  localparam fbar_pkg::sensor_t SwRightCentre = 5'b11100;
  localparam fbar_pkg::sensor_t SwBothOpen    = 5'b00000;
  localparam fbar_pkg::sensor_t SwLidOnly     = 5'b10101;
  localparam fbar_pkg::sensor_t SwAllSet      = 5'b11111;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_right_side_closed = 1'b1;
  logic in_right_centre_closed = 1'b0;
  logic in_left_side_closed = 1'b1;
  logic in_left_centre_closed = 1'b0;
  logic in_lid_open = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_report_valid;
  logic [fbar_pkg::CodeW-1:0] out_report_code;
  logic out_alert_active;
  logic out_left_alarm;
  logic out_right_alarm;
  logic cfg_write_en = 1'b0;
  logic [fbar_pkg::CfgIdxW-1:0] cfg_index = fbar_pkg::REG_BREACH_TICKS;
  logic [fbar_pkg::CfgDataW-1:0] cfg_data = '0;

  fence_breach_alarm_reporter u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_right_side_closed   (in_right_side_closed),
    .in_right_centre_closed (in_right_centre_closed),
    .in_left_side_closed    (in_left_side_closed),
    .in_left_centre_closed  (in_left_centre_closed),
    .in_lid_open            (in_lid_open),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_report_valid       (out_report_valid),
    .out_report_code        (out_report_code),
    .out_alert_active       (out_alert_active),
    .out_left_alarm         (out_left_alarm),
    .out_right_alarm        (out_right_alarm),
    .cfg_write_en           (cfg_write_en),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state and register copy
  logic [fbar_pkg::IntervalW-1:0] breach_lim = fbar_pkg::BreachTicksRst;
  logic [fbar_pkg::IntervalW-1:0] report_gap = fbar_pkg::AlertIntTicksRst;
  logic [fbar_pkg::TimerW-1:0]    beat_lim   = fbar_pkg::HeartbeatTicksRst;
  logic                           l_prev = 1'b0;
  logic                           r_prev = 1'b0;
  logic [fbar_pkg::TimerW-1:0]    l_elapsed = '0;
  logic [fbar_pkg::TimerW-1:0]    r_elapsed = '0;
  logic [fbar_pkg::TimerW-1:0]    quiet_ticks = '0;
  logic                           alert_on = 1'b0;
  fbar_pkg::cause_t               alert_why = fbar_pkg::CAUSE_HEARTBEAT;

  fbar_pkg::sensor_t tick_q[$];
  fbar_pkg::result_t status_due_q[$];
  int unsigned ticks_sent = 0;
  int unsigned ticks_taken = 0;
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_wait = 0;
  int unsigned out_calm = 0;
  int unsigned hold_left = 0;

  function automatic logic [fbar_pkg::TimerW-1:0] sat_up(logic [fbar_pkg::TimerW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [fbar_pkg::CodeW-1:0] code_for(fbar_pkg::cause_t c, logic l,
                                                          logic r, logic lid);
    logic [fbar_pkg::CodeW-1:0] base;
    case (c)
      fbar_pkg::CAUSE_LEFT:  base = fbar_pkg::CodeBaseLeft;
      fbar_pkg::CAUSE_RIGHT: base = fbar_pkg::CodeBaseRight;
      fbar_pkg::CAUSE_LID:   base = fbar_pkg::CodeBaseLid;
      default:               base = fbar_pkg::CodeBaseHeartbeat;
    endcase
    return base + (l ? 14'd1 : 14'd0) + (r ? 14'd2 : 14'd0) + (lid ? 14'd5 : 14'd0);
  endfunction

  function automatic fbar_pkg::result_t predict_tick(fbar_pkg::sensor_t s);
    fbar_pkg::result_t r;
    logic left;
    logic right;
    left  = !(s.left_side_closed && !s.left_centre_closed);
    right = !(s.right_side_closed && !s.right_centre_closed);
    r = '0;
    l_elapsed   = sat_up(l_elapsed);
    r_elapsed   = sat_up(r_elapsed);
    quiet_ticks = sat_up(quiet_ticks);
    if (right && !r_prev) r_elapsed = '0;
    r_prev = right;
    if (left && !l_prev) l_elapsed = '0;
    l_prev = left;
    if (!alert_on && left && l_elapsed > breach_lim) begin
      alert_on  = 1'b1;
      alert_why = fbar_pkg::CAUSE_LEFT;
    end
    if (!alert_on && right && r_elapsed > breach_lim) begin
      alert_on  = 1'b1;
      alert_why = fbar_pkg::CAUSE_RIGHT;
    end
    if (!alert_on && s.lid_open) begin
      alert_on  = 1'b1;
      alert_why = fbar_pkg::CAUSE_LID;
    end
    if (alert_on && quiet_ticks > report_gap) begin
      r.report_valid = 1'b1;
      r.report_code  = code_for(alert_why, left, right, s.lid_open);
      quiet_ticks    = '0;
    end
    if (alert_on && !s.lid_open && !left && !right) begin
      alert_on    = 1'b0;
      quiet_ticks = '0;
    end
    if (quiet_ticks > beat_lim) begin
      alert_why      = fbar_pkg::CAUSE_HEARTBEAT;
      r.report_valid = 1'b1;
      r.report_code  = code_for(alert_why, left, right, s.lid_open);
      quiet_ticks    = '0;
    end
    r.alert_active = alert_on;
    r.left_alarm   = left;
    r.right_alarm  = right;
    return r;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [1:0] side_pair(logic alarm);
    int unsigned pick;
    if (!alarm) return 2'b10;
    pick = $urandom_range(0, 2);
    return (pick == 0) ? 2'b00 : (pick == 1) ? 2'b01 : 2'b11;
  endfunction

  task automatic push_ticks(input fbar_pkg::sensor_t s, input int unsigned n);
    repeat (n) begin
      tick_q.push_back(s);
      ticks_sent++;
    end
  endtask

  task automatic queue_fence_run(input int unsigned n);
    int unsigned run;
    logic l;
    logic r;
    logic lid;
    logic [4:0] noise;
    fbar_pkg::sensor_t s;
    while (n != 0) begin
      l   = ($urandom_range(0, 99) < 40);
      r   = ($urandom_range(0, 99) < 40);
      lid = ($urandom_range(0, 99) < 12);
      run = $urandom_range(1, 24);
      while (run != 0 && n != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          noise = 5'($urandom);
          s = noise;
        end else begin
          {s.left_side_closed, s.left_centre_closed}   = side_pair(l);
          {s.right_side_closed, s.right_centre_closed} = side_pair(r);
          s.lid_open = lid;
        end
        tick_q.push_back(s);
        ticks_sent++;
        run--;
        n--;
      end
    end
  endtask

  task automatic write_reg(input logic [fbar_pkg::CfgIdxW-1:0] idx,
                           input logic [fbar_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      fbar_pkg::REG_BREACH_TICKS:    breach_lim = data[fbar_pkg::IntervalW-1:0];
      fbar_pkg::REG_ALERT_INTERVAL:  report_gap = data[fbar_pkg::IntervalW-1:0];
      fbar_pkg::REG_HEARTBEAT_TICKS: beat_lim   = data[fbar_pkg::TimerW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic settle();
    while (ticks_taken != ticks_sent || status_due_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin : drive_ticks
    fbar_pkg::sensor_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (tick_q.size() != 0) begin
        s = tick_q.pop_front();
        in_valid <= 1'b1;
        {in_right_side_closed, in_right_centre_closed, in_left_side_closed,
         in_left_centre_closed, in_lid_open} <= s;
        in_gap = draw_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      status_due_q.push_back(predict_tick({in_right_side_closed, in_right_centre_closed,
                                           in_left_side_closed, in_left_centre_closed,
                                           in_lid_open}));
      ticks_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_acc) out_wait = draw_wait(out_calm);
      if (hold_done != hold_reqs) begin
        hold_left = LongHoldCycles;
        hold_done++;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (out_wait != 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_status
    fbar_pkg::result_t want;
    out_acc <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (status_due_q.size() == 0) begin
          $error("status item with none expected");
          mismatches++;
        end else begin
          want = status_due_q.pop_front();
          check_field("report_valid", 32'(want.report_valid), 32'(out_report_valid));
          check_field("report_code", 32'(want.report_code), 32'(out_report_code));
          check_field("alert_active", 32'(want.alert_active), 32'(out_alert_active));
          check_field("left_alarm", 32'(want.left_alarm), 32'(out_left_alarm));
          check_field("right_alarm", 32'(want.right_alarm), 32'(out_right_alarm));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("fence_breach_alarm_reporter: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned p;
    logic [fbar_pkg::IntervalW-1:0] brk;
    logic [fbar_pkg::IntervalW-1:0] gap;
    logic [fbar_pkg::TimerW-1:0] beat;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_fence_run(16);
    settle();

    write_reg(fbar_pkg::REG_BREACH_TICKS, {16'hA5C3, 16'd2});
    write_reg(fbar_pkg::REG_ALERT_INTERVAL, {16'hFFFF, 16'd6});
    write_reg(fbar_pkg::REG_HEARTBEAT_TICKS, 32'd4);
    write_reg(RegIdxSpare, 32'hFFFF_FFFF);
    push_ticks(SwQuiet, 5);
    push_ticks(SwLeftOpen, 4);
    push_ticks(SwLeftCentre, 3);
    push_ticks(SwRightCentre, 3);
    push_ticks(SwBothOpen, 2);
    push_ticks(SwLidOnly, 2);
    push_ticks(SwAllSet, 2);
    push_ticks(SwQuiet, 3);
    settle();

    for (p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          brk = '0; gap = '0; beat = '0;
        end
        1: begin
          brk = '1; gap = '1; beat = '1;
        end
        2: begin
          brk = '1; gap = '0; beat = 32'd1;
        end
        3: begin
          brk = '0; gap = '1; beat = '1;
        end
        default: begin
          brk  = 16'($urandom_range(0, 12));
          gap  = 16'($urandom_range(0, 10));
          beat = $urandom_range(0, 40);
        end
      endcase
      write_reg(fbar_pkg::REG_BREACH_TICKS, {16'($urandom), brk});
      write_reg(fbar_pkg::REG_ALERT_INTERVAL, {16'($urandom), gap});
      write_reg(fbar_pkg::REG_HEARTBEAT_TICKS, beat);
      if (p % 3 == 0) write_reg(RegIdxSpare, $urandom);
      if (p % 4 == 1) hold_reqs++;
      queue_fence_run(PhaseTicks);
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && status_due_q.size() == 0) begin
      $display("fence_breach_alarm_reporter: match");
    end else begin
      $display("fence_breach_alarm_reporter: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/fbar_pkg.sv
hw/rtl/fbar_tick.sv
hw/rtl/fence_breach_alarm_reporter.sv
dv/tb_fence_breach_alarm_reporter.sv
